FILE: src/sliding_window_median_filter_assert.svh
// assertion macros for the running median filter
// used by the top level only; expects clk and arst_n in scope
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define SWMF_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("swmf invariant violated");
// implication checked in the cycle after the trigger
`define SWMF_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("swmf sequencing violated");
// implication checked in the same cycle
`define SWMF_ASSERT_SAME(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error("swmf state check violated");
`else
`define SWMF_ASSERT_ALWAYS(lbl, cond)
`define SWMF_ASSERT_NEXT(lbl, trig, cons)
`define SWMF_ASSERT_SAME(lbl, trig, cons)
`endif
`endif

FILE: src/swmf_pkg.sv
// shared types for the running median filter
// no dependencies
`timescale 1ns / 1ps

package swmf_pkg;

	// sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_UPDATE = 3'b010,
		ST_RESULT = 3'b100
	} swmf_state_t;

	// command broadcast to every cell of the sorted chain
	typedef struct packed {
		logic evict;
		logic insert;
	} swmf_cmd_t;

endpackage

FILE: src/swmf_cell.sv
// one cell of the sorted sample chain: value, age and valid flag
// depends on swmf_pkg
`timescale 1ns / 1ps

module swmf_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int AGE_BITS    = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swmf_pkg::swmf_cmd_t           cmd,
	input  logic signed [SAMPLE_BITS-1:0] fresh,
	input  logic [AGE_BITS-1:0]           age_limit,
	input  logic                          prev_valid,
	input  logic                          prev_gt,
	input  logic signed [SAMPLE_BITS-1:0] prev_val,
	input  logic [AGE_BITS-1:0]           prev_age,
	input  logic                          next_valid,
	input  logic signed [SAMPLE_BITS-1:0] next_val,
	input  logic [AGE_BITS-1:0]           next_age,
	input  logic                          kill_in,
	output logic                          valid,
	output logic signed [SAMPLE_BITS-1:0] val,
	output logic [AGE_BITS-1:0]           age,
	output logic                          gt,
	output logic                          kill_out
);
	import swmf_pkg::*;

	logic                          valid_q, valid_d;
	logic signed [SAMPLE_BITS-1:0] val_q, val_d;
	logic [AGE_BITS-1:0]           age_q, age_d;
	logic                          doom;

	// empty cells sort above everything
	assign gt       = !valid_q || (val_q > fresh);
	assign doom     = valid_q && (age_q >= age_limit);
	assign kill_out = kill_in || doom;

	always_comb begin
		valid_d = valid_q;
		val_d   = val_q;
		age_d   = age_q;
		if (cmd.evict && kill_out) begin
			// close the gap left by the lowest doomed cell
			valid_d = next_valid;
			val_d   = next_val;
			age_d   = next_age;
		end else if (cmd.insert) begin
			if (gt && prev_gt) begin
				valid_d = prev_valid;
				val_d   = prev_val;
				age_d   = prev_age + AGE_BITS'(1);
			end else if (gt) begin
				valid_d = 1'b1;
				val_d   = fresh;
				age_d   = '0;
			end else begin
				age_d = age_q + AGE_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		age_q <= age_d;
	end

	assign valid = valid_q;
	assign val   = val_q;
	assign age   = age_q;

endmodule

FILE: src/sliding_window_median_filter.sv
// running median filter top level: sequencer, sorted cell chain, output register
// depends on swmf_pkg, swmf_cell and sliding_window_median_filter_assert.svh
`timescale 1ns / 1ps
// usage
// - input channel in_valid/in_ready carries one signed sample per beat
// - output channel out_valid/out_ready carries filtered and window_full per beat,
//   exactly one output beat for every input beat, in order
// - config channel cfg_valid/cfg_ready/cfg_data writes window_length (always ready);
//   write it only while the filter is idle, 0 acts as 1, above MAX_WINDOW saturates
// - the window lives in a chain of MAX_WINDOW cells kept sorted ascending, each cell
//   tagged with the age of its sample; the median is the cell at rank length/2
// - per sample: the beat is taken, each aged-out sample is dropped from the chain in
//   turn, then the new sample is inserted and the result registered
// - one sample is in process at a time: a new beat is taken only once the last
//   result is in the output register; after the length is shortened the next
//   sample first drops every surplus sample that has to leave the chain
// - reset clears the chain, the fill count and the output valid flag and restores a
//   window length of 5; no clearing pass is needed
// - a stalled receiver holds the result in the output register; the next sample
//   is still taken and processed, then waits until the register drains
`include "sliding_window_median_filter_assert.svh"

module sliding_window_median_filter #(
	parameter int MAX_WINDOW  = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// result output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          window_full,
	// window length register write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [5:0]                    cfg_data
);
	import swmf_pkg::*;

	// length and age width, index width into the chain
	localparam int LW = $clog2(MAX_WINDOW + 1);
	localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	swmf_state_t                   state_q, state_d;
	logic [5:0]                    window_length_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [LW-1:0]                 fill_q;
	logic [LW-1:0]                 leff;
	logic [LW-1:0]                 age_limit;
	logic [IW-1:0]                 mid_idx;
	swmf_cmd_t                     cmd;
	logic                          any_doom;
	logic                          load_out;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;
	logic                          window_full_q;
	logic                          full_now;

	// chain wiring: entry 0 and MAX_WINDOW+1 are the boundaries, cell i sits at i+1
	logic signed [SAMPLE_BITS-1:0] v_c [MAX_WINDOW+2];
	logic [LW-1:0]                 a_c [MAX_WINDOW+2];
	logic [MAX_WINDOW+1:0]         vld_c;
	logic [MAX_WINDOW:0]           gt_c;
	logic [MAX_WINDOW:0]           kill_c;
	logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= 6'd5;
		end else if (cfg_valid && cfg_ready) begin
			window_length_q <= cfg_data;
		end
	end

	// effective length, clamped to 1..MAX_WINDOW
	always_comb begin
		if (window_length_q == '0) begin
			leff = LW'(1);
		end else if (int'(window_length_q) > MAX_WINDOW) begin
			leff = LW'(MAX_WINDOW);
		end else begin
			leff = LW'(window_length_q);
		end
	end

	// samples this old or older cannot stay once the new one arrives
	assign age_limit = leff - LW'(1);
	assign mid_idx   = IW'(leff >> 1);

	// chain boundaries
	assign v_c[0]              = '0;
	assign a_c[0]              = '0;
	assign vld_c[0]            = 1'b0;
	assign v_c[MAX_WINDOW+1]   = '0;
	assign a_c[MAX_WINDOW+1]   = '0;
	assign vld_c[MAX_WINDOW+1] = 1'b0;
	assign gt_c[0]             = 1'b0;
	assign kill_c[0]           = 1'b0;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swmf_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.AGE_BITS    (LW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.fresh      (sample_q),
			.age_limit  (age_limit),
			.prev_valid (vld_c[i]),
			.prev_gt    (gt_c[i]),
			.prev_val   (v_c[i]),
			.prev_age   (a_c[i]),
			.next_valid (vld_c[i+2]),
			.next_val   (v_c[i+2]),
			.next_age   (a_c[i+2]),
			.kill_in    (kill_c[i]),
			.valid      (vld_c[i+1]),
			.val        (v_c[i+1]),
			.age        (a_c[i+1]),
			.gt         (gt_c[i+1]),
			.kill_out   (kill_c[i+1])
		);
		assign cell_val[i] = v_c[i+1];
	end

	// some cell still holds a sample outside the window
	assign any_doom = kill_c[MAX_WINDOW];

	// sequencer: drop aged-out samples one per cycle, then insert
	always_comb begin
		state_d    = state_q;
		cmd.evict  = 1'b0;
		cmd.insert = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (any_doom) begin
					cmd.evict = 1'b1;
				end else begin
					cmd.insert = 1'b1;
					state_d    = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_RESULT) && (!out_valid_q || out_ready);
	assign full_now = (fill_q == leff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.insert) begin
				fill_q <= fill_q + LW'(1);
			end else if (cmd.evict) begin
				fill_q <= fill_q - LW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sample beat and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_q <= sample;
		end
		if (load_out) begin
			window_full_q <= full_now;
			filtered_q    <= full_now ? cell_val[mid_idx] : sample_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign filtered    = filtered_q;
	assign window_full = window_full_q;

	// the fill count tracks the occupied cells of the chain
	`SWMF_ASSERT_ALWAYS(a_fill_matches_chain, $countones(vld_c) == int'(fill_q))
	// at result time the window holds between one and length samples
	`SWMF_ASSERT_SAME(a_fill_in_range, state_q == ST_RESULT, fill_q != '0 && fill_q <= leff)
	// an accepted sample starts the chain update on the next cycle
	`SWMF_ASSERT_NEXT(a_accept_starts_update, in_valid && in_ready, state_q == ST_UPDATE)
	// a result taken into the output register is offered next cycle
	`SWMF_ASSERT_NEXT(a_result_offered, load_out, out_valid && state_q == ST_IDLE)

endmodule

FILE: tb/tb_top.sv
// self-checking bench for the running median filter: random beats on all three channels
// checked against a behavioural window model kept inside the bench; needs only the filter rtl
`timescale 1ns / 1ps

module tb_top;

	localparam int WIN_MAX  = 32;
	localparam int SAMPLE_W = 16;

	// what the stimulus queue can hold: a sample beat or a window length write
	typedef enum logic {
		JOB_SAMPLE,
		JOB_LENGTH
	} job_kind_t;

	typedef struct {
		job_kind_t                   kind;
		logic signed [SAMPLE_W-1:0]  value;
		logic [5:0]                  length;
		logic                        steady;   // no idling on either side around this beat
	} job_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       full;
	} filter_out_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] filtered;
	logic                       window_full;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [5:0]                 cfg_data = '0;

	job_t        pending_beats[$];
	filter_out_t owed_results[$];

	// window model, touched only by the checker
	logic signed [SAMPLE_W-1:0] win_ring [WIN_MAX];
	logic [4:0]                 win_wr;
	int                         win_fill;
	logic [5:0]                 win_len;

	int   in_flight = 0;        // samples taken whose result has not drained yet
	int   gap_left = 0;
	int   stall_left = 0;
	logic steady_now = 1'b0;
	int   mismatches = 0;
	int   results_seen = 0;

	sliding_window_median_filter #(
		.MAX_WINDOW (WIN_MAX),
		.SAMPLE_BITS(SAMPLE_W)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered   (filtered),
		.window_full(window_full),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// one step of the running median: store the sample, age the window, pick rank len/2
	function automatic filter_out_t median_step(input logic signed [SAMPLE_W-1:0] fresh);
		logic signed [SAMPLE_W-1:0] sorted [WIN_MAX];
		logic signed [SAMPLE_W-1:0] v;
		logic [4:0]                 idx;
		int                         span, j, k;
		filter_out_t                r;
		// zero behaves as one, anything past the ring depth is clipped to it
		span = (win_len == 0) ? 1 : ((win_len > WIN_MAX) ? WIN_MAX : int'(win_len));
		win_ring[win_wr] = fresh;
		win_wr = win_wr + 5'd1;
		// a shortened window clamps the fill at once
		win_fill = (win_fill + 1 > span) ? span : win_fill + 1;
		if (win_fill < span) begin
			r.filtered = fresh;
			r.full = 1'b0;
		end else begin
			// oldest slot is write pointer minus span, wrapping at the ring depth
			idx = win_wr - 5'(span);
			for (k = 0; k < span; k++) begin
				v = win_ring[idx];
				j = k;
				while (j > 0 && sorted[j-1] > v) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = v;
				idx = idx + 5'd1;
			end
			r.filtered = sorted[span/2];
			r.full = 1'b1;
		end
		return r;
	endfunction

	// sender: takes jobs from the queue, holds a beat until it is taken,
	// and only writes the length once every owed result has drained
	always @(posedge clk or negedge arst_n) begin : drive_proc
		int   nxt_flight;
		logic offer_sample, offer_cfg;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			in_flight <= 0;
			steady_now <= 1'b0;
			gap_left = 0;
		end else begin
			nxt_flight = in_flight + int'(in_valid && in_ready) - int'(out_valid && out_ready);
			in_flight <= nxt_flight;
			// a beat still waiting for ready keeps valid and payload as they are
			if (!(in_valid && !in_ready) && !(cfg_valid && !cfg_ready)) begin
				offer_sample = 1'b0;
				offer_cfg = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_beats.size() != 0) begin
					case (pending_beats[0].kind)
						JOB_SAMPLE: begin
							offer_sample = 1'b1;
							sample <= pending_beats[0].value;
							steady_now <= pending_beats[0].steady;
							if (!pending_beats[0].steady && $urandom_range(0, 4) == 0)
								gap_left = $urandom_range(1, 9);
							void'(pending_beats.pop_front());
						end
						JOB_LENGTH: begin
							// register writes only with the filter idle
							if (nxt_flight == 0) begin
								offer_cfg = 1'b1;
								cfg_data <= pending_beats[0].length;
								void'(pending_beats.pop_front());
							end
						end
						default: ;
					endcase
				end
				in_valid <= offer_sample;
				cfg_valid <= offer_cfg;
			end
		end
	end

	// receiver back-pressure in bursts, switched off for steady stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!steady_now && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 9);
		end
	end

	// checker: result beats first, then length writes, then new samples into the model
	always @(posedge clk or negedge arst_n) begin : check_proc
		filter_out_t want;
		if (!arst_n) begin
			win_wr = '0;
			win_fill = 0;
			win_len = 6'd5;
			foreach (win_ring[i])
				win_ring[i] = '0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d unexpected: filtered %0d window_full %0b",
							results_seen, filtered, window_full);
				end else begin
					want = owed_results.pop_front();
					if (filtered !== want.filtered) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d filtered: expected %0d got %0d",
								results_seen, want.filtered, filtered);
					end
					if (window_full !== want.full) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d window_full: expected %0b got %0b",
								results_seen, want.full, window_full);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				win_len = cfg_data;
			if (in_valid && in_ready)
				owed_results.push_back(median_step(sample));
		end
	end

	task automatic push_sample(input int value, input logic steady);
		job_t j;
		j.kind = JOB_SAMPLE;
		j.value = SAMPLE_W'(value);
		j.length = '0;
		j.steady = steady;
		pending_beats.push_back(j);
	endtask

	task automatic push_length(input int length);
		job_t j;
		j.kind = JOB_LENGTH;
		j.value = '0;
		j.length = 6'(length);
		j.steady = 1'b0;
		pending_beats.push_back(j);
	endtask

	// stimulus: a short directed run, then random phases each opened by a length write
	initial begin
		int   total, n, len, style, span, v, phase;
		logic quiet;

		// reset length of five: extremes while filling, then medians over them
		push_sample(-32768, 0);
		push_sample(32767, 0);
		push_sample(0, 0);
		push_sample(-1, 0);
		push_sample(1, 0);
		push_sample(32767, 0);
		push_sample(-32768, 0);
		// zero acts as one and shortens a full window of five at once
		push_length(0);
		push_sample(32767, 0);
		push_sample(-32768, 0);
		push_sample(5, 0);
		// lengthened to an even window, upper median
		push_length(2);
		push_sample(-7, 0);
		push_sample(9, 0);
		push_sample(-3, 0);
		push_length(1);
		push_sample(100, 0);
		push_sample(-100, 0);
		// lengthened again, with repeated values
		push_length(4);
		push_sample(3, 0);
		push_sample(3, 0);
		push_sample(-3, 0);
		push_sample(3, 0);
		push_sample(-3, 0);
		// shortened from four to three
		push_length(3);
		push_sample(32767, 0);
		push_sample(-32768, 0);

		total = 0;
		phase = 0;
		while (total < 450) begin
			// first phases hit the top of the range: full depth, just past it, all ones
			case (phase)
				0: len = 32;
				1: len = 63;
				2: len = 33;
				default: len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
					: $urandom_range(1, 9);
			endcase
			phase++;
			push_length(len);
			span = (len == 0) ? 1 : ((len > WIN_MAX) ? WIN_MAX : len);
			n = (span > 16) ? $urandom_range(span + 2, span + 24) : $urandom_range(8, 36);
			// keep the run close to its planned length
			if (n > 450 - total)
				n = 450 - total;
			quiet = ($urandom_range(0, 3) == 0);
			style = $urandom_range(0, 2);
			for (int i = 0; i < n; i++) begin
				case (style)
					0: v = $urandom_range(0, 65535) - 32768;
					1: v = $urandom_range(0, 8) - 4;       // many ties
					default: begin
						case ($urandom_range(0, 5))
							0: v = -32768;
							1: v = 32767;
							2: v = -1;
							3: v = 0;
							4: v = 1;
							default: v = $urandom_range(0, 65535) - 32768;
						endcase
					end
				endcase
				// the tail of the run goes without idling on either side
				push_sample(v, quiet || total > 410);
				total++;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_beats.size() != 0 || in_valid || cfg_valid || in_flight != 0);
		repeat (10) @(negedge clk);

		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// watchdog, well past the slowest legal run
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule
